>>> rtl/core/afr_pkg.sv
// Shared types and constants for the adapter frame receiver.
`default_nettype none
package afr_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0]  START_BYTE     = 8'h02;
	localparam logic [15:0] TYPE_NORMAL    = 16'h0003;
	localparam logic [7:0]  CMD_RESPONSE   = 8'h90;
	localparam logic [7:0]  CMD_NOTIFY_REQ = 8'h11;
	localparam logic [15:0] HEADER_LEN     = 16'd7;

	localparam logic [15:0] GAP_LIMIT_RESET = 16'd100;
	localparam logic [9:0]  MAX_LEN_RESET   = 10'd256;

	localparam logic [10:0] POS_TYPE_HI = 11'd1;
	localparam logic [10:0] POS_TYPE_LO = 11'd2;
	localparam logic [10:0] POS_CMD     = 11'd3;
	localparam logic [10:0] POS_LEN_HI  = 11'd5;
	localparam logic [10:0] POS_LEN_LO  = 11'd6;

	typedef enum logic [0:0] {
		CFG_GAP_LIMIT = 1'b0,
		CFG_MAX_LEN   = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_WAIT     = 3'd0,
		ST_OK       = 3'd1,
		ST_NO_START = 3'd2,
		ST_BAD_LEN  = 3'd3,
		ST_BAD_SUM  = 3'd4,
		ST_READ_ERR = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		KIND_OTHER    = 2'd0,
		KIND_RESPONSE = 2'd1,
		KIND_NOTIFY   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [15:0] gap_ms;
		logic        read_error;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [10:0] byte_pos;
		logic [7:0]  data_byte;
		logic        last;
		logic        gap_reset;
		kind_t       frame_kind;
	} out_item_t;

	// classified byte as it travels through the queue
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       gap_over;
		logic       read_error;
		logic       is_start;
	} cls_item_t;

endpackage
`default_nettype wire

>>> rtl/core/adapter_frame_receiver_core.sv
// Top level of the adapter frame receiver: config registers, classifier, queue, frame engine.
// An accepted transaction is written into the queue, then into the frame engine's output register
// when that register is free, and is shown on out_data from there.
// Throughput: one byte per cycle; the front stalls only when the queue holds QUEUE_DEPTH
// entries, which happens only while out_ready is held low.
// Reset (arst_n low): queue empty, no result pending, frame state cleared,
// gap_limit_ms = 100, max_data_len = 256.
`default_nettype none
module adapter_frame_receiver_core #(
	parameter int unsigned QUEUE_DEPTH = afr_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire afr_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output afr_pkg::out_item_t     out_data,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);
	import afr_pkg::*;

	logic [15:0] gap_limit_q;
	logic [9:0]  max_len_q;
	logic        q_full;
	logic        q_push;
	logic        q_not_empty;
	logic        q_pop;
	cls_item_t   q_wdata;
	cls_item_t   q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RESET;
			max_len_q   <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_GAP_LIMIT: gap_limit_q <= cfg_data;
				CFG_MAX_LEN:   max_len_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	afr_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.gap_limit_q (gap_limit_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	afr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.rdata     (q_rdata)
	);

	afr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_pop       (q_pop),
		.q_rdata     (q_rdata),
		.max_len_q   (max_len_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

>>> rtl/core/afr_front.sv
// Front end: accepts received bytes and classifies them for the frame engine.
`default_nettype none
module afr_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire afr_pkg::in_item_t in_data,
	input  wire logic [15:0]       gap_limit_q,
	input  wire logic              q_full,
	output logic                   q_push,
	output afr_pkg::cls_item_t     q_wdata
);
	import afr_pkg::*;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_wdata.rx_byte    = in_data.rx_byte;
		q_wdata.gap_over   = in_data.gap_ms > gap_limit_q;
		q_wdata.read_error = in_data.read_error;
		q_wdata.is_start   = in_data.rx_byte == START_BYTE;
	end

endmodule
`default_nettype wire

>>> rtl/core/afr_queue.sv
// Short queue between the classifier and the frame engine.
`default_nettype none
module afr_queue #(
	parameter int unsigned DEPTH = afr_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire afr_pkg::cls_item_t wdata,
	output logic                    full,
	output logic                    not_empty,
	input  wire logic               pop,
	output afr_pkg::cls_item_t      rdata
);
	import afr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	cls_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign not_empty = count_q != '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/afr_back.sv
// Back end: frame state, checksum and length checks, registered result.
`default_nettype none
module afr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_not_empty,
	output logic                    q_pop,
	input  wire afr_pkg::cls_item_t q_rdata,
	input  wire logic [9:0]         max_len_q,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output afr_pkg::out_item_t      out_data
);
	import afr_pkg::*;

	logic [10:0] byte_count_q;
	logic [7:0]  running_sum_q;
	logic [15:0] data_len_q;
	logic [15:0] frame_type_q;
	logic [7:0]  command_code_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic [10:0] pos;
	logic [10:0] count_nxt;
	logic [7:0]  sum_nxt;
	logic [7:0]  sum_add;
	logic [15:0] len_nxt;
	logic [15:0] type_nxt;
	logic [7:0]  cmd_nxt;
	logic [15:0] len_full;
	out_item_t   res;

	assign q_pop     = q_not_empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign sum_add   = running_sum_q + q_rdata.rx_byte;
	assign len_full  = {data_len_q[15:8], q_rdata.rx_byte};

	always_comb begin
		pos       = q_rdata.gap_over ? '0 : byte_count_q;
		count_nxt = pos;
		sum_nxt   = q_rdata.gap_over ? '0 : running_sum_q;
		len_nxt   = data_len_q;
		type_nxt  = frame_type_q;
		cmd_nxt   = command_code_q;

		res.status     = ST_WAIT;
		res.byte_pos   = pos;
		res.data_byte  = q_rdata.rx_byte;
		res.last       = 1'b0;
		res.gap_reset  = q_rdata.gap_over && (byte_count_q != '0);
		res.frame_kind = KIND_OTHER;

		if (q_rdata.read_error) begin
			res.status    = ST_READ_ERR;
			res.last      = 1'b1;
			res.data_byte = '0;
			count_nxt     = '0;
			sum_nxt       = '0;
		end else if (pos == '0) begin
			sum_nxt = '0;
			if (!q_rdata.is_start) begin
				res.status = ST_NO_START;
				res.last   = 1'b1;
				count_nxt  = '0;
			end else begin
				count_nxt = 11'd1;
			end
		end else begin
			sum_nxt   = sum_add;
			count_nxt = pos + 11'd1;
			case (pos)
				POS_TYPE_HI: type_nxt = {q_rdata.rx_byte, 8'h00};
				POS_TYPE_LO: type_nxt = {frame_type_q[15:8], q_rdata.rx_byte};
				POS_CMD:     cmd_nxt  = q_rdata.rx_byte;
				POS_LEN_HI:  len_nxt  = {q_rdata.rx_byte, 8'h00};
				POS_LEN_LO: begin
					len_nxt = len_full;
					if (len_full > {6'd0, max_len_q}) begin
						res.status = ST_BAD_LEN;
						res.last   = 1'b1;
						count_nxt  = '0;
						sum_nxt    = '0;
					end
				end
				default: begin
					if ({6'd0, pos} >= {1'b0, data_len_q} + {1'b0, HEADER_LEN}) begin
						res.last  = 1'b1;
						count_nxt = '0;
						sum_nxt   = '0;
						if (sum_add == '0) begin
							res.status = ST_OK;
							if (frame_type_q == TYPE_NORMAL) begin
								if (command_code_q == CMD_RESPONSE) begin
									res.frame_kind = KIND_RESPONSE;
								end else if (command_code_q == CMD_NOTIFY_REQ) begin
									res.frame_kind = KIND_NOTIFY;
								end
							end
						end else begin
							res.status = ST_BAD_SUM;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			data_len_q     <= '0;
			frame_type_q   <= '0;
			command_code_q <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q    <= 1'b1;
				byte_count_q   <= count_nxt;
				running_sum_q  <= sum_nxt;
				data_len_q     <= len_nxt;
				frame_type_q   <= type_nxt;
				command_code_q <= cmd_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Testbench for adapter_frame_receiver_core: random framed byte traffic checked by a cycle-free predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import afr_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 370;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_GAP_LIMIT;
	logic [15:0] cfg_data = '0;

	adapter_frame_receiver_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	in_item_t pending_bytes[$];
	out_item_t expected_verdicts[$];
	logic [7:0] frame_bytes[$];

	// limit registers as the block holds them
	logic [15:0] lim_gap = GAP_LIMIT_RESET;
	logic [9:0] lim_len = MAX_LEN_RESET;

	// frame tracking state
	logic [10:0] held_count = '0;
	logic [7:0] held_sum = '0;
	logic [15:0] hdr_len = '0;
	logic [15:0] hdr_type = '0;
	logic [7:0] hdr_cmd = '0;

	int items_queued = 0;
	int bytes_accepted = 0;
	int fail_count = 0;
	int settings_used = 1;
	int gap_resets_seen = 0;
	int status_seen[6] = '{default: 0};
	int in_hold = 0;
	int out_hold = 0;
	int quiet_cycles = 0;
	bit in_steady = 1'b0;
	bit out_steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
		fail_count++;
	endtask

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic follow_frame_byte(input in_item_t it);
		out_item_t r;
		logic [10:0] pos;
		r.status = ST_WAIT;
		r.data_byte = it.rx_byte;
		r.last = 1'b0;
		r.gap_reset = 1'b0;
		r.frame_kind = KIND_OTHER;
		if (it.gap_ms > lim_gap) begin
			if (held_count != 0)
				r.gap_reset = 1'b1;
			held_count = '0;
			held_sum = '0;
		end
		pos = held_count;
		r.byte_pos = pos;
		if (it.read_error) begin
			r.status = ST_READ_ERR;
			r.last = 1'b1;
			r.data_byte = '0;
			held_count = '0;
			held_sum = '0;
		end else if (pos == 0) begin
			if (it.rx_byte != START_BYTE) begin
				r.status = ST_NO_START;
				r.last = 1'b1;
			end else begin
				held_count = 11'd1;
			end
			held_sum = '0;
		end else begin
			held_sum = held_sum + it.rx_byte;
			held_count = pos + 11'd1;
			case (pos)
				POS_TYPE_HI: hdr_type = {it.rx_byte, 8'h00};
				POS_TYPE_LO: hdr_type[7:0] = it.rx_byte;
				POS_CMD: hdr_cmd = it.rx_byte;
				POS_LEN_HI: hdr_len = {it.rx_byte, 8'h00};
				POS_LEN_LO: begin
					hdr_len[7:0] = it.rx_byte;
					if (hdr_len > {6'd0, lim_len}) begin
						r.status = ST_BAD_LEN;
						r.last = 1'b1;
					end
				end
				default: begin
					if (int'(pos) >= int'(HEADER_LEN) + int'(hdr_len)) begin
						r.last = 1'b1;
						if (held_sum == 0) begin
							r.status = ST_OK;
							if (hdr_type == TYPE_NORMAL && hdr_cmd == CMD_RESPONSE)
								r.frame_kind = KIND_RESPONSE;
							else if (hdr_type == TYPE_NORMAL && hdr_cmd == CMD_NOTIFY_REQ)
								r.frame_kind = KIND_NOTIFY;
						end else begin
							r.status = ST_BAD_SUM;
						end
					end
				end
			endcase
			if (r.last) begin
				held_count = '0;
				held_sum = '0;
			end
		end
		expected_verdicts.push_back(r);
	endtask

	// input side: feed pending bytes with random idle cycles
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_hold <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_hold > 0) begin
				in_valid <= 1'b0;
				in_hold <= in_hold - 1;
			end else if (pending_bytes.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_bytes.pop_front();
				if ($urandom_range(0, 49) == 0)
					in_steady = !in_steady;
				in_hold <= in_steady ? 0 : pick_pause();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			follow_frame_byte(in_data);
			bytes_accepted++;
		end
	end

	// output side: random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_hold <= 0;
		end else if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 49) == 0)
				out_steady = !out_steady;
			if (!out_steady && $urandom_range(0, 99) < 30)
				out_hold <= pick_pause();
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (int'(out_data.status) < 6)
				status_seen[int'(out_data.status)]++;
			if (out_data.gap_reset)
				gap_resets_seen++;
			if (expected_verdicts.size() == 0) begin
				report_mismatch("transaction with none pending", int'(out_data.status), -1);
			end else begin
				want = expected_verdicts.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.byte_pos != want.byte_pos)
					report_mismatch("byte_pos", out_data.byte_pos, want.byte_pos);
				if (out_data.data_byte != want.data_byte)
					report_mismatch("data_byte", out_data.data_byte, want.data_byte);
				if (out_data.last != want.last)
					report_mismatch("last", out_data.last, want.last);
				if (out_data.gap_reset != want.gap_reset)
					report_mismatch("gap_reset", out_data.gap_reset, want.gap_reset);
				if (out_data.frame_kind != want.frame_kind)
					report_mismatch("frame_kind", out_data.frame_kind, want.frame_kind);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic [15:0] gap, input bit err);
		in_item_t it;
		it.rx_byte = b;
		it.gap_ms = gap;
		it.read_error = err;
		pending_bytes.push_back(it);
		items_queued++;
	endtask

	function automatic logic [15:0] ok_gap();
		if (lim_gap == 0)
			return 16'd0;
		if ($urandom_range(0, 99) < 70)
			return 16'($urandom_range(0, lim_gap < 20 ? int'(lim_gap) : 20));
		return 16'($urandom_range(0, int'(lim_gap)));
	endfunction

	function automatic logic [15:0] any_gap();
		if ($urandom_range(0, 99) < 60)
			return ok_gap();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [15:0] over_gap();
		return 16'($urandom_range(int'(lim_gap) + 1, 65535));
	endfunction

	function automatic int rand_len();
		if (lim_len > 64 && $urandom_range(0, 99) < 3)
			return $urandom_range(64, int'(lim_len));
		return $urandom_range(0, lim_len < 12 ? int'(lim_len) : 12);
	endfunction

	// data and check bytes are only added when the length is acceptable
	task automatic build_frame(input logic [15:0] ftype, input logic [7:0] cmd,
			input logic [15:0] len, input bit bad_sum);
		logic [7:0] sum;
		logic [7:0] check;
		int i;
		frame_bytes.delete();
		frame_bytes.push_back(START_BYTE);
		frame_bytes.push_back(ftype[15:8]);
		frame_bytes.push_back(ftype[7:0]);
		frame_bytes.push_back(cmd);
		frame_bytes.push_back(8'($urandom()));
		frame_bytes.push_back(len[15:8]);
		frame_bytes.push_back(len[7:0]);
		if (len <= {6'd0, lim_len}) begin
			repeat (len) frame_bytes.push_back(8'($urandom()));
			sum = '0;
			for (i = 1; i < frame_bytes.size(); i++)
				sum = sum + frame_bytes[i];
			check = 8'd0 - sum;
			if (bad_sum)
				check = check + 8'($urandom_range(1, 255));
			frame_bytes.push_back(check);
		end
	endtask

	task automatic emit_frame(input logic [15:0] first_gap, input int count);
		int i;
		for (i = 0; i < count; i++)
			queue_byte(frame_bytes[i], i == 0 ? first_gap : ok_gap(), 1'b0);
	endtask

	task automatic queue_scenario();
		int pick;
		int cut;
		logic [15:0] ftype;
		logic [7:0] cmd;
		pick = $urandom_range(0, 99);
		ftype = ($urandom_range(0, 9) < 6) ? TYPE_NORMAL : 16'($urandom());
		case ($urandom_range(0, 2))
			0: cmd = CMD_RESPONSE;
			1: cmd = CMD_NOTIFY_REQ;
			default: cmd = 8'($urandom());
		endcase
		if (pick < 52) begin
			build_frame(ftype, cmd, 16'(rand_len()), 1'b0);
			emit_frame(any_gap(), frame_bytes.size());
		end else if (pick < 62) begin
			build_frame(ftype, cmd, 16'(rand_len()), 1'b1);
			emit_frame(any_gap(), frame_bytes.size());
		end else if (pick < 70) begin
			build_frame(ftype, cmd, 16'(rand_len()), 1'b0);
			cut = $urandom_range(0, frame_bytes.size() - 1);
			emit_frame(any_gap(), cut);
			queue_byte(8'($urandom()), ok_gap(), 1'b1);
		end else if (pick < 78 && lim_gap != 16'hFFFF) begin
			// partial frame dropped by an idle gap, then a fresh frame
			build_frame(ftype, cmd, 16'(rand_len()), 1'b0);
			cut = $urandom_range(1, frame_bytes.size() - 1);
			emit_frame(any_gap(), cut);
			build_frame(ftype, cmd, 16'(rand_len()), 1'b0);
			emit_frame(over_gap(), frame_bytes.size());
		end else if (pick < 85) begin
			build_frame(ftype, cmd, 16'($urandom_range(int'(lim_len) + 1, 65535)), 1'b0);
			emit_frame(any_gap(), 7);
		end else if (pick < 92) begin
			repeat ($urandom_range(1, 3))
				queue_byte(8'($urandom()), any_gap(), $urandom_range(0, 3) == 0);
		end else if (lim_len <= 64) begin
			build_frame(ftype, cmd, {6'd0, lim_len}, 1'b0);
			emit_frame(any_gap(), frame_bytes.size());
		end else begin
			build_frame(ftype, cmd, {6'd0, lim_len} + 16'd1, 1'b0);
			emit_frame(any_gap(), 7);
		end
	endtask

	task automatic wait_for_drain();
		@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [15:0] gap_lim, input logic [9:0] len_lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GAP_LIMIT;
		cfg_data <= gap_lim;
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= {6'd0, len_lim};
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_gap = gap_lim;
		lim_len = len_lim;
		settings_used++;
	endtask

	initial begin
		logic [15:0] gap_set[5];
		logic [9:0] len_set[5];
		int phase;
		int target;
		gap_set = '{GAP_LIMIT_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd3};
		len_set = '{MAX_LEN_RESET, 10'd0, 10'd1023, 10'($urandom_range(1, 1022)), 10'd16};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_byte(8'h00, 16'd0, 1'b0);
		queue_byte(8'hFF, 16'hFFFF, 1'b0);
		queue_byte(8'hAA, 16'd0, 1'b1);
		build_frame(TYPE_NORMAL, CMD_RESPONSE, 16'd0, 1'b0);
		emit_frame(16'd0, frame_bytes.size());
		// start byte, then a long gap drops it; the next frame has a bad check
		queue_byte(START_BYTE, 16'd0, 1'b0);
		build_frame(TYPE_NORMAL, CMD_NOTIFY_REQ, 16'd0, 1'b1);
		emit_frame(16'hFFFF, frame_bytes.size());
		build_frame(TYPE_NORMAL, CMD_NOTIFY_REQ, 16'hFFFF, 1'b0);
		emit_frame(16'd0, 7);

		for (phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_for_drain();
				set_limits(gap_set[phase], len_set[phase]);
			end
			target = items_queued + PHASE_ITEMS;
			while (items_queued < target)
				queue_scenario();
		end

		wait_for_drain();
		repeat (6) @(posedge clk);
		$display("%0d bytes over %0d limit settings: %0d ok, %0d no start, %0d bad length,",
			bytes_accepted, settings_used, status_seen[ST_OK], status_seen[ST_NO_START],
			status_seen[ST_BAD_LEN]);
		$display("%0d bad checksum, %0d read errors, %0d gap resets", status_seen[ST_BAD_SUM],
			status_seen[ST_READ_ERR], gap_resets_seen);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/core/afr_pkg.sv
rtl/core/afr_front.sv
rtl/core/afr_queue.sv
rtl/core/afr_back.sv
rtl/core/adapter_frame_receiver_core.sv
bench/tb.sv
